// ----- rtl/tbbeq_pkg.sv -----
// Shared constants, types and command encodings of the three-band biquad equalizer.
package tbbeq_pkg;

	// Parameter defaults
	localparam int DEF_NUM_CHANNELS   = 2;
	localparam int DEF_SAMPLE_BITS    = 24;
	localparam int DEF_COEF_FRAC_BITS = 16;

	// Fixed datapath widths
	localparam int NUM_BANDS = 3;
	localparam int BAND_W    = 2;
	localparam int COEF_W    = 20;
	localparam int DELAY_W   = 32;
	localparam int PROD_W    = COEF_W + DELAY_W;
	localparam int CHANNEL_W = 1;
	localparam int FF_W      = 3 * COEF_W;
	localparam int FB_W      = 2 * COEF_W;

	// Configuration port
	localparam int NUM_REGS  = 6;
	localparam int PDATA_W   = 64;
	localparam int PADDR_W   = 6;
	localparam int ADDR_LSB  = 3;
	localparam int REG_IDX_W = PADDR_W - ADDR_LSB;

	localparam logic [REG_IDX_W-1:0] REG_LOW_FF  = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_LOW_FB  = REG_IDX_W'(1);
	localparam logic [REG_IDX_W-1:0] REG_MID_FF  = REG_IDX_W'(2);
	localparam logic [REG_IDX_W-1:0] REG_MID_FB  = REG_IDX_W'(3);
	localparam logic [REG_IDX_W-1:0] REG_HIGH_FF = REG_IDX_W'(4);
	localparam logic [REG_IDX_W-1:0] REG_HIGH_FB = REG_IDX_W'(5);

	localparam logic [FF_W-1:0] FF_RESET = FF_W'(65536);
	localparam logic [FB_W-1:0] FB_RESET = '0;

	// Band codes, in cascade order
	localparam logic [BAND_W-1:0] BAND_LOW  = BAND_W'(0);
	localparam logic [BAND_W-1:0] BAND_MID  = BAND_W'(1);
	localparam logic [BAND_W-1:0] BAND_HIGH = BAND_W'(2);

	// Multiplier operand selection
	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_B0X,
		MUL_B1X,
		MUL_B2X,
		MUL_A1Y,
		MUL_A2Y
	} mul_op_t;

	// First accumulator operations
	typedef enum logic [2:0] {
		ACC_HOLD,
		ACC_LOAD_Z1,
		ACC_ADD,
		ACC_Z2_ADD,
		ACC_SUB
	} acc_a_op_t;

	// Second accumulator operations
	typedef enum logic [1:0] {
		ACCB_HOLD,
		ACCB_LOAD,
		ACCB_SUB
	} acc_b_op_t;

	// Round, saturate and write-back targets
	typedef enum logic [1:0] {
		RND_NONE,
		RND_Y,
		RND_Z1,
		RND_Z2
	} rnd_op_t;

	typedef struct packed {
		logic                    load_x;
		logic                    adv_x;
		logic                    load_out;
		logic [BAND_W-1:0]       band;
		logic [BAND_W-1:0]       z2_band;
		mul_op_t                 mul_op;
		acc_a_op_t               acc_a_op;
		acc_b_op_t               acc_b_op;
		rnd_op_t                 rnd_op;
	} cmd_t;

	typedef struct packed {
		logic bypass;
	} stat_t;

	typedef struct packed {
		logic [NUM_BANDS-1:0][FF_W-1:0] ff;
		logic [NUM_BANDS-1:0][FB_W-1:0] fb;
	} coef_bank_t;

endpackage

// ----- rtl/tbbeq_if.sv -----
// Valid/ready stream interfaces for equalizer input samples and results.
interface tbbeq_in_if #(
	parameter int SAMPLE_BITS = tbbeq_pkg::DEF_SAMPLE_BITS
) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_in;
	logic                          channel;
	logic                          last_in;

	modport source (output valid, output sample_in, output channel, output last_in,
		input ready);
	modport sink (input valid, input sample_in, input channel, input last_in,
		output ready);
endinterface

interface tbbeq_out_if #(
	parameter int SAMPLE_BITS = tbbeq_pkg::DEF_SAMPLE_BITS
) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_out;
	logic                          channel_out;
	logic                          clipped;
	logic                          last_out;

	modport source (output valid, output sample_out, output channel_out, output clipped,
		output last_out, input ready);
	modport sink (input valid, input sample_out, input channel_out, input clipped,
		input last_out, output ready);
endinterface

// ----- rtl/tbbeq_cfg.sv -----
// APB coefficient register file; a write to a coefficient register clears the filter state.
module tbbeq_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tbbeq_pkg::PADDR_W-1:0] paddr,
	input  logic [tbbeq_pkg::PDATA_W-1:0] pwdata,
	output logic [tbbeq_pkg::PDATA_W-1:0] prdata,
	output logic                          pready,
	output tbbeq_pkg::coef_bank_t         coefs,
	output logic                          clr_state
);
	import tbbeq_pkg::*;

	logic [REG_IDX_W-1:0]           reg_idx;
	logic                           wr_en;
	logic [NUM_BANDS-1:0][FF_W-1:0] ff_q;
	logic [NUM_BANDS-1:0][FB_W-1:0] fb_q;

	assign reg_idx = paddr[PADDR_W-1:ADDR_LSB];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	// Flush delay registers on any write to a real register
	assign clr_state = wr_en && (int'(reg_idx) < NUM_REGS);

	// Capture register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < NUM_BANDS; b++) begin
				ff_q[b] <= FF_RESET;
				fb_q[b] <= FB_RESET;
			end
		end else if (wr_en) begin
			case (reg_idx)
				REG_LOW_FF:  ff_q[BAND_LOW]  <= pwdata[FF_W-1:0];
				REG_LOW_FB:  fb_q[BAND_LOW]  <= pwdata[FB_W-1:0];
				REG_MID_FF:  ff_q[BAND_MID]  <= pwdata[FF_W-1:0];
				REG_MID_FB:  fb_q[BAND_MID]  <= pwdata[FB_W-1:0];
				REG_HIGH_FF: ff_q[BAND_HIGH] <= pwdata[FF_W-1:0];
				REG_HIGH_FB: fb_q[BAND_HIGH] <= pwdata[FB_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (reg_idx)
			REG_LOW_FF:  prdata = PDATA_W'(ff_q[BAND_LOW]);
			REG_LOW_FB:  prdata = PDATA_W'(fb_q[BAND_LOW]);
			REG_MID_FF:  prdata = PDATA_W'(ff_q[BAND_MID]);
			REG_MID_FB:  prdata = PDATA_W'(fb_q[BAND_MID]);
			REG_HIGH_FF: prdata = PDATA_W'(ff_q[BAND_HIGH]);
			REG_HIGH_FB: prdata = PDATA_W'(fb_q[BAND_HIGH]);
			default:     prdata = '0;
		endcase
	end

	assign coefs.ff = ff_q;
	assign coefs.fb = fb_q;

endmodule

// ----- rtl/tbbeq_ctrl.sv -----
// Sequencer that schedules the fifteen products of the three biquad stages.
module tbbeq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  tbbeq_pkg::stat_t  stat,
	output tbbeq_pkg::cmd_t   cmd
);
	import tbbeq_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_TAIL,
		ST_FINISH
	} state_t;

	// Phases inside one band
	localparam logic [2:0] PH_MUL_B0 = 3'd0;
	localparam logic [2:0] PH_MUL_B1 = 3'd1;
	localparam logic [2:0] PH_MUL_B2 = 3'd2;
	localparam logic [2:0] PH_MUL_A1 = 3'd3;
	localparam logic [2:0] PH_MUL_A2 = 3'd4;
	localparam logic [2:0] PH_WB_Z1  = 3'd5;

	state_t            state_q;
	logic [2:0]        phase_q;
	logic [BAND_W-1:0] band_q;
	logic              out_valid_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// Decode the datapath command for this cycle
	always_comb begin
		cmd.load_x   = (state_q == ST_IDLE) && in_valid;
		cmd.adv_x    = 1'b0;
		cmd.load_out = (state_q == ST_FINISH) && (!out_valid_q || out_ready);
		cmd.band     = band_q;
		cmd.z2_band  = band_q - BAND_W'(1);
		cmd.mul_op   = MUL_NONE;
		cmd.acc_a_op = ACC_HOLD;
		cmd.acc_b_op = ACCB_HOLD;
		cmd.rnd_op   = RND_NONE;
		case (state_q)
			ST_RUN: begin
				if (!stat.bypass) begin
					case (phase_q)
						PH_MUL_B0: begin
							cmd.mul_op   = MUL_B0X;
							cmd.acc_a_op = ACC_LOAD_Z1;
							// finish the previous band's second delay
							if (band_q != BAND_LOW) cmd.rnd_op = RND_Z2;
						end
						PH_MUL_B1: begin
							cmd.mul_op   = MUL_B1X;
							cmd.acc_a_op = ACC_ADD;
						end
						PH_MUL_B2: begin
							cmd.mul_op   = MUL_B2X;
							cmd.acc_a_op = ACC_Z2_ADD;
							cmd.rnd_op   = RND_Y;
						end
						PH_MUL_A1: begin
							cmd.mul_op   = MUL_A1Y;
							cmd.acc_b_op = ACCB_LOAD;
						end
						PH_MUL_A2: begin
							cmd.mul_op   = MUL_A2Y;
							cmd.acc_a_op = ACC_SUB;
						end
						PH_WB_Z1: begin
							cmd.rnd_op   = RND_Z1;
							cmd.acc_b_op = ACCB_SUB;
							cmd.adv_x    = 1'b1;
						end
						default: ;
					endcase
				end
			end
			ST_TAIL: begin
				cmd.rnd_op  = RND_Z2;
				cmd.z2_band = BAND_HIGH;
			end
			default: ;
		endcase
	end

	// Advance the state, band and phase; hold the result valid until transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_MUL_B0;
			band_q      <= BAND_LOW;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_RUN;
						phase_q <= PH_MUL_B0;
						band_q  <= BAND_LOW;
					end
				end
				ST_RUN: begin
					if (stat.bypass) begin
						state_q <= ST_FINISH;
					end else if (phase_q == PH_WB_Z1) begin
						phase_q <= PH_MUL_B0;
						if (band_q == BAND_HIGH) begin
							state_q <= ST_TAIL;
						end else begin
							band_q <= band_q + BAND_W'(1);
						end
					end else begin
						phase_q <= phase_q + 3'd1;
					end
				end
				ST_TAIL: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (cmd.load_out) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/tbbeq_dp.sv -----
// Shared-multiplier biquad datapath with per-channel delay registers.
module tbbeq_dp #(
	parameter int NUM_CHANNELS   = tbbeq_pkg::DEF_NUM_CHANNELS,
	parameter int SAMPLE_BITS    = tbbeq_pkg::DEF_SAMPLE_BITS,
	parameter int COEF_FRAC_BITS = tbbeq_pkg::DEF_COEF_FRAC_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tbbeq_pkg::cmd_t               cmd,
	output tbbeq_pkg::stat_t              stat,
	input  tbbeq_pkg::coef_bank_t         coefs,
	input  logic                          clr_state,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	input  logic                          channel,
	input  logic                          last_in,
	output logic signed [SAMPLE_BITS-1:0] sample_out,
	output logic                          channel_out,
	output logic                          clipped,
	output logic                          last_out
);
	import tbbeq_pkg::*;

	// Only channels reachable through the channel field keep state
	localparam int STATE_CH = (NUM_CHANNELS < (1 << CHANNEL_W)) ? NUM_CHANNELS
		: (1 << CHANNEL_W);
	localparam int ENT      = NUM_BANDS * STATE_CH;
	localparam int ENT_W    = $clog2(ENT);
	localparam int ACC_W    = ((DELAY_W + COEF_FRAC_BITS > PROD_W) ?
		DELAY_W + COEF_FRAC_BITS : PROD_W) + 2;

	localparam logic signed [ACC_W-1:0]       RND_HALF = ACC_W'(1 << (COEF_FRAC_BITS - 1));
	localparam logic signed [DELAY_W-1:0]     DLY_MAX  = {1'b0, {(DELAY_W-1){1'b1}}};
	localparam logic signed [DELAY_W-1:0]     DLY_MIN  = {1'b1, {(DELAY_W-1){1'b0}}};
	localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX  = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN  = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	logic signed [DELAY_W-1:0] z1_q [ENT];
	logic signed [DELAY_W-1:0] z2_q [ENT];

	logic signed [DELAY_W-1:0]     x_q;
	logic signed [DELAY_W-1:0]     y_q;
	logic signed [PROD_W-1:0]      prod_q;
	logic signed [ACC_W-1:0]       acc_a_q;
	logic signed [ACC_W-1:0]       acc_b_q;
	logic                          ch_q;
	logic                          last_q;
	logic                          bypass_q;
	logic signed [SAMPLE_BITS-1:0] sample_out_q;
	logic                          channel_out_q;
	logic                          clipped_q;
	logic                          last_out_q;

	logic [FF_W-1:0]           ff_sel;
	logic [FB_W-1:0]           fb_sel;
	logic signed [COEF_W-1:0]  coef_op;
	logic signed [DELAY_W-1:0] mul_opnd;
	logic signed [PROD_W-1:0]  prod_c;
	logic [ENT_W-1:0]          idx_rd;
	logic [ENT_W-1:0]          idx_z2;
	logic signed [DELAY_W-1:0] z1_rd;
	logic signed [DELAY_W-1:0] z2_rd;
	logic signed [ACC_W-1:0]   rnd_src;
	logic signed [ACC_W-1:0]   rnd_sum;
	logic signed [ACC_W-1:0]   rnd_shift;
	logic signed [DELAY_W-1:0] rnd_res;
	logic signed [DELAY_W-1:0] x_ext;
	logic                      y_fits;

	function automatic logic [ENT_W-1:0] ent_idx(input logic [BAND_W-1:0] b, input logic c);
		ent_idx = ENT_W'(int'(b) * STATE_CH + ((STATE_CH > 1) ? int'(c) : 0));
	endfunction

	assign stat.bypass = bypass_q;
	assign x_ext       = DELAY_W'(sample_in);

	// Select coefficient and operand for the shared multiplier
	assign ff_sel = coefs.ff[cmd.band];
	assign fb_sel = coefs.fb[cmd.band];
	always_comb begin
		case (cmd.mul_op)
			MUL_B0X: begin
				coef_op  = ff_sel[0*COEF_W +: COEF_W];
				mul_opnd = x_q;
			end
			MUL_B1X: begin
				coef_op  = ff_sel[1*COEF_W +: COEF_W];
				mul_opnd = x_q;
			end
			MUL_B2X: begin
				coef_op  = ff_sel[2*COEF_W +: COEF_W];
				mul_opnd = x_q;
			end
			MUL_A1Y: begin
				coef_op  = fb_sel[0*COEF_W +: COEF_W];
				mul_opnd = y_q;
			end
			MUL_A2Y: begin
				coef_op  = fb_sel[1*COEF_W +: COEF_W];
				mul_opnd = y_q;
			end
			default: begin
				coef_op  = '0;
				mul_opnd = x_q;
			end
		endcase
	end
	assign prod_c = coef_op * mul_opnd;

	// Delay register reads for this band and channel
	assign idx_rd = ent_idx(cmd.band, ch_q);
	assign idx_z2 = ent_idx(cmd.z2_band, ch_q);
	assign z1_rd  = z1_q[idx_rd];
	assign z2_rd  = z2_q[idx_rd];

	// Round half up, then saturate to 32 bits
	assign rnd_src   = (cmd.rnd_op == RND_Z2) ? acc_b_q : acc_a_q;
	assign rnd_sum   = rnd_src + RND_HALF;
	assign rnd_shift = rnd_sum >>> COEF_FRAC_BITS;
	always_comb begin
		if ((&rnd_shift[ACC_W-1:DELAY_W-1]) || !(|rnd_shift[ACC_W-1:DELAY_W-1])) begin
			rnd_res = rnd_shift[DELAY_W-1:0];
		end else if (rnd_shift[ACC_W-1]) begin
			rnd_res = DLY_MIN;
		end else begin
			rnd_res = DLY_MAX;
		end
	end

	assign y_fits = (&y_q[DELAY_W-1:SAMPLE_BITS-1]) || !(|y_q[DELAY_W-1:SAMPLE_BITS-1]);

	// Delay registers: clear on reset or coefficient write, write back from rounder
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int e = 0; e < ENT; e++) begin
				z1_q[e] <= '0;
				z2_q[e] <= '0;
			end
		end else if (clr_state) begin
			for (int e = 0; e < ENT; e++) begin
				z1_q[e] <= '0;
				z2_q[e] <= '0;
			end
		end else begin
			if (cmd.rnd_op == RND_Z1) z1_q[idx_rd] <= rnd_res;
			if (cmd.rnd_op == RND_Z2) z2_q[idx_z2] <= rnd_res;
		end
	end

	// Bypass flag for channels without state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bypass_q <= 1'b0;
		end else if (cmd.load_x) begin
			bypass_q <= (int'(channel) >= NUM_CHANNELS);
		end
	end

	// Sample, product and accumulator registers
	always_ff @(posedge clk) begin
		if (cmd.load_x) begin
			x_q    <= x_ext;
			y_q    <= x_ext;
			ch_q   <= channel;
			last_q <= last_in;
		end else begin
			if (cmd.adv_x) x_q <= y_q;
			if (cmd.rnd_op == RND_Y) y_q <= rnd_res;
		end

		if (cmd.mul_op != MUL_NONE) prod_q <= prod_c;

		case (cmd.acc_a_op)
			ACC_LOAD_Z1: acc_a_q <= ACC_W'(z1_rd) <<< COEF_FRAC_BITS;
			ACC_ADD:     acc_a_q <= acc_a_q + ACC_W'(prod_q);
			ACC_Z2_ADD:  acc_a_q <= (ACC_W'(z2_rd) <<< COEF_FRAC_BITS) + ACC_W'(prod_q);
			ACC_SUB:     acc_a_q <= acc_a_q - ACC_W'(prod_q);
			default: ;
		endcase

		case (cmd.acc_b_op)
			ACCB_LOAD: acc_b_q <= ACC_W'(prod_q);
			ACCB_SUB:  acc_b_q <= acc_b_q - ACC_W'(prod_q);
			default: ;
		endcase

		// Saturate the cascade output into the result register
		if (cmd.load_out) begin
			channel_out_q <= ch_q;
			last_out_q    <= last_q;
			clipped_q     <= !y_fits;
			if (y_fits) begin
				sample_out_q <= y_q[SAMPLE_BITS-1:0];
			end else if (y_q[DELAY_W-1]) begin
				sample_out_q <= SMP_MIN;
			end else begin
				sample_out_q <= SMP_MAX;
			end
		end
	end

	assign sample_out  = sample_out_q;
	assign channel_out = channel_out_q;
	assign clipped     = clipped_q;
	assign last_out    = last_out_q;

endmodule

// ----- rtl/three_band_biquad_eq.sv -----
// Three-band equalizer: low shelf, peak and high shelf biquads in cascade, one sample at a time.
// Each sample runs through three transposed direct-form-II stages on a single shared
// 20x32 multiplier, five products per band, followed by a rounding tail state and a result
// state: a sample is taken only after the last one has left the result state, and a channel
// without filter state passes through without the filter stages. The result sits in an
// output register, so the next sample is taken while an earlier result waits for transfer.
// Coefficients are signed Q4.16 fields packed in six 64-bit-wide APB registers at byte
// addresses 0, 8, ... 40; a write to any of them clears the delay registers of every channel
// in the same cycle, with no clearing pass.
module three_band_biquad_eq #(
	parameter int NUM_CHANNELS   = tbbeq_pkg::DEF_NUM_CHANNELS,
	parameter int SAMPLE_BITS    = tbbeq_pkg::DEF_SAMPLE_BITS,
	parameter int COEF_FRAC_BITS = tbbeq_pkg::DEF_COEF_FRAC_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tbbeq_pkg::PADDR_W-1:0] paddr,
	input  logic [tbbeq_pkg::PDATA_W-1:0] pwdata,
	output logic [tbbeq_pkg::PDATA_W-1:0] prdata,
	output logic                          pready,
	tbbeq_in_if.sink                      in_ch,
	tbbeq_out_if.source                   out_ch
);
	import tbbeq_pkg::*;

	coef_bank_t coefs;
	logic       clr_state;
	cmd_t       cmd;
	stat_t      stat;

	// Coefficient registers
	tbbeq_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.coefs     (coefs),
		.clr_state (clr_state)
	);

	// Sequencer
	tbbeq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Filter datapath
	tbbeq_dp #(
		.NUM_CHANNELS   (NUM_CHANNELS),
		.SAMPLE_BITS    (SAMPLE_BITS),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.coefs       (coefs),
		.clr_state   (clr_state),
		.sample_in   (in_ch.sample_in),
		.channel     (in_ch.channel),
		.last_in     (in_ch.last_in),
		.sample_out  (out_ch.sample_out),
		.channel_out (out_ch.channel_out),
		.clipped     (out_ch.clipped),
		.last_out    (out_ch.last_out)
	);

endmodule

// ----- rtl/tbbeq_checker.sv -----
// Port-level assertions for the equalizer, bound to the top level.
module tbbeq_checker (
	input logic         clk,
	input logic         arst_n,
	tbbeq_in_if.sink    in_ch,
	tbbeq_out_if.source out_ch
);
	logic [1:0] pend_q;
	logic       in_xfer;
	logic       out_xfer;

	assign in_xfer  = in_ch.valid && in_ch.ready;
	assign out_xfer = out_ch.valid && out_ch.ready;

	// Track samples taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 2'd0;
		end else if (in_xfer && !out_xfer) begin
			pend_q <= pend_q + 2'd1;
		end else if (out_xfer && !in_xfer) begin
			pend_q <= pend_q - 2'd1;
		end
	end

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> $stable(out_ch.sample_out)
			&& $stable(out_ch.channel_out) && $stable(out_ch.clipped)
			&& $stable(out_ch.last_out))
		else $error("stalled result changed");

	// Sequencer goes busy after each input transfer
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !in_ch.ready)
		else $error("input taken while a sample is in work");

	// No result without a sample behind it
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> pend_q != 2'd0)
		else $error("result with no pending sample");

	// At most one sample in work and one waiting result
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("too many samples in flight");

endmodule

bind three_band_biquad_eq tbbeq_checker u_tbbeq_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.in_ch  (in_ch),
	.out_ch (out_ch)
);
